@@ sv/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Line pixel rasteriser package
// Shared constants, register indexes and the screen configuration type.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // Default coordinate width
  localparam int unsigned CoordBitsDef = 8;
  // Fixed field widths
  localparam int unsigned ColorW  = 16;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 2;
  // Depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] ScreenWidthRst  = 9'd128;
  localparam logic [CfgW-1:0] ScreenHeightRst = 9'd160;

  // Operation codes carried in tuser
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // Screen bounds as seen by the walker
  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [CfgW-1:0] height;
  } screen_cfg_t;

endpackage

@@ sv/line_pixel_rasterizer.sv @@
// Path: a step beat goes through the queue register, then the output register,
// on its way to its pixel beat; a start beat gives no pixel.
// Throughput: one beat per cycle on either side while m_axis_tready is high,
// set by the combinational error add and compare of the walker.
// Reset: asynchronous, active low; line inactive, screen 128 by 160.
// ----------------------------------------------------------------------------
// Line pixel rasteriser top level
// Bresenham line walker with a set-up front end, a short queue and a pixel
// output register, plus the screen size registers.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer #(
  parameter int unsigned COORD_BITS  = lpr_pkg::CoordBitsDef,
  parameter int unsigned QUEUE_DEPTH = lpr_pkg::QueueDepthDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Input beats
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // tdata: x_start, y_start, x_end, y_end, pen_color (lowest bit up)
  input  logic [((4*COORD_BITS+lpr_pkg::ColorW+7)/8)*8-1:0] s_axis_tdata,
  // tuser: operation
  input  logic                                        s_axis_tuser,
  // Pixel beats
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // tdata: pixel_x, pixel_y, pixel_color (lowest bit up)
  output logic [((2*COORD_BITS+lpr_pkg::ColorW+7)/8)*8-1:0] m_axis_tdata,
  // tuser: on_screen
  output logic                                        m_axis_tuser,
  // tlast: last_pixel
  output logic                                        m_axis_tlast,
  // Configuration writes
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [lpr_pkg::CfgIdxW-1:0]                 cfg_index_i,
  input  logic [lpr_pkg::CfgW-1:0]                    cfg_data_i
);
  import lpr_pkg::*;

  localparam int unsigned EntryW = 3 + 5 * COORD_BITS + ColorW;
  localparam int unsigned OutW   = ((2 * COORD_BITS + ColorW + 7) / 8) * 8;

  screen_cfg_t           scr_q;
  logic [EntryW-1:0]     entry, q_data;
  logic                  q_valid, q_ready;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [ColorW-1:0]     pix_col;

  // Screen size registers; writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_q.width  <= ScreenWidthRst;
      scr_q.height <= ScreenHeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegScreenWidth:  scr_q.width  <= cfg_data_i;
        RegScreenHeight: scr_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classification and line set-up
  lpr_front #(
    .COORD_BITS(COORD_BITS),
    .EntryW    (EntryW)
  ) u_front (
    .op_i   (s_axis_tuser),
    .xa_i   (s_axis_tdata[COORD_BITS-1:0]),
    .ya_i   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .xb_i   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .yb_i   (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .color_i(s_axis_tdata[4*COORD_BITS+ColorW-1:4*COORD_BITS]),
    .entry_o(entry)
  );

  // Decoupling queue
  lpr_queue #(
    .DataW(EntryW),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(s_axis_tvalid),
    .push_ready_o(s_axis_tready),
    .push_data_i (entry),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_data)
  );

  // Walker and output register
  lpr_back #(
    .COORD_BITS(COORD_BITS),
    .EntryW    (EntryW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scr_i        (scr_q),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_data_i     (q_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pixel_x_o    (pix_x),
    .pixel_y_o    (pix_y),
    .pixel_color_o(pix_col),
    .on_screen_o  (m_axis_tuser),
    .last_pixel_o (m_axis_tlast)
  );

  assign m_axis_tdata = OutW'({pix_col, pix_y, pix_x});

endmodule

@@ sv/lpr_front.sv @@
// ----------------------------------------------------------------------------
// Line pixel rasteriser front end
// Classifies each input beat and, for a start beat, works out the line setup:
// major axis, endpoint order, minor direction and both spans.
// ----------------------------------------------------------------------------
module lpr_front #(
  parameter int unsigned COORD_BITS = lpr_pkg::CoordBitsDef,
  parameter int unsigned EntryW     = 3 + 5 * COORD_BITS + lpr_pkg::ColorW
) (
  input  logic                         op_i,
  input  logic [COORD_BITS-1:0]        xa_i,
  input  logic [COORD_BITS-1:0]        ya_i,
  input  logic [COORD_BITS-1:0]        xb_i,
  input  logic [COORD_BITS-1:0]        yb_i,
  input  logic [lpr_pkg::ColorW-1:0]   color_i,
  output logic [EntryW-1:0]            entry_o
);
  import lpr_pkg::*;

  logic [COORD_BITS-1:0] dx, dy;
  logic                  steep;
  logic [COORD_BITS-1:0] a0, a1, b0, b1;
  logic [COORD_BITS-1:0] maj0, maj1, min0, min1;
  logic                  minor_down;
  logic [COORD_BITS-1:0] maj_span, min_span;
  logic                  is_start;

  // Extents and choice of the major axis
  assign dx    = (xa_i > xb_i) ? (xa_i - xb_i) : (xb_i - xa_i);
  assign dy    = (ya_i > yb_i) ? (ya_i - yb_i) : (yb_i - ya_i);
  assign steep = dy > dx;

  assign a0 = steep ? ya_i : xa_i;
  assign b0 = steep ? xa_i : ya_i;
  assign a1 = steep ? yb_i : xb_i;
  assign b1 = steep ? xb_i : yb_i;

  // Order endpoints so the walk runs upward along the major axis
  always_comb begin
    if (a0 > a1) begin
      maj0 = a1;
      maj1 = a0;
      min0 = b1;
      min1 = b0;
    end else begin
      maj0 = a0;
      maj1 = a1;
      min0 = b0;
      min1 = b1;
    end
  end

  assign minor_down = !(min0 < min1);
  assign maj_span   = maj1 - maj0;
  assign min_span   = minor_down ? (min0 - min1) : (min1 - min0);
  assign is_start   = (op_i == OpStart);

  assign entry_o = {is_start, steep, minor_down, maj0, maj1, min0,
                    maj_span, min_span, color_i};

endmodule

@@ sv/lpr_queue.sv @@
// ----------------------------------------------------------------------------
// Line pixel rasteriser queue
// Short first-in first-out queue between the front end and the walker.
// ----------------------------------------------------------------------------
module lpr_queue #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = lpr_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [DataW-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [DataW-1:0] pop_data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/lpr_back.sv @@
// ----------------------------------------------------------------------------
// Line pixel rasteriser walker
// Holds the line state, walks the major axis one pixel per step beat with an
// exact integer error term, and drives the output register.
// ----------------------------------------------------------------------------
module lpr_back #(
  parameter int unsigned COORD_BITS = lpr_pkg::CoordBitsDef,
  parameter int unsigned EntryW     = 3 + 5 * COORD_BITS + lpr_pkg::ColorW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpr_pkg::screen_cfg_t        scr_i,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [EntryW-1:0]           q_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [COORD_BITS-1:0]       pixel_x_o,
  output logic [COORD_BITS-1:0]       pixel_y_o,
  output logic [lpr_pkg::ColorW-1:0]  pixel_color_o,
  output logic                        on_screen_o,
  output logic                        last_pixel_o
);
  import lpr_pkg::*;

  // Error term range is [-span, 3*span), so three extra bits suffice
  localparam int unsigned ErrW = COORD_BITS + 3;

  // Queue entry fields
  logic                  e_start, e_steep, e_down;
  logic [COORD_BITS-1:0] e_maj0, e_maj1, e_min0, e_maj_span, e_min_span;
  logic [ColorW-1:0]     e_color;

  // Line state
  logic                  active_q, steep_q, down_q;
  logic [COORD_BITS-1:0] maj_pos_q, maj_stop_q, min_pos_q, maj_span_q, min_span_q;
  logic signed [ErrW-1:0] err_q;
  logic [ColorW-1:0]     color_q;

  // Output register
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [ColorW-1:0]     pcol_q;
  logic                  onscr_q, last_q;

  logic                   out_free, pop, do_start, do_step;
  logic signed [ErrW-1:0] err_sum;
  logic                   take_minor;
  logic [COORD_BITS-1:0]  maj_next, px, py;
  logic                   onscr;

  assign {e_start, e_steep, e_down, e_maj0, e_maj1, e_min0,
          e_maj_span, e_min_span, e_color} = q_data_i;

  // Pop rules: starts and idle steps never wait for the output slot
  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = e_start || !active_q || out_free;
  assign pop       = q_valid_i && q_ready_o;
  assign do_start  = pop && e_start;
  assign do_step   = pop && !e_start && active_q;

  // One Bresenham step
  assign err_sum    = err_q + $signed({2'b00, min_span_q, 1'b0});
  assign take_minor = err_sum >= $signed({3'b000, maj_span_q});
  assign maj_next   = maj_pos_q + COORD_BITS'(1);

  assign px    = steep_q ? min_pos_q : maj_pos_q;
  assign py    = steep_q ? maj_pos_q : min_pos_q;
  assign onscr = ({{CfgW{1'b0}}, px} < {{COORD_BITS{1'b0}}, scr_i.width}) &&
                 ({{CfgW{1'b0}}, py} < {{COORD_BITS{1'b0}}, scr_i.height});

  // Line state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      steep_q    <= 1'b0;
      down_q     <= 1'b0;
      maj_pos_q  <= '0;
      maj_stop_q <= '0;
      min_pos_q  <= '0;
      maj_span_q <= '0;
      min_span_q <= '0;
      err_q      <= '0;
      color_q    <= '0;
    end else if (do_start) begin
      active_q   <= (e_maj_span != '0);
      steep_q    <= e_steep;
      down_q     <= e_down;
      maj_pos_q  <= e_maj0;
      maj_stop_q <= e_maj1;
      min_pos_q  <= e_min0;
      maj_span_q <= e_maj_span;
      min_span_q <= e_min_span;
      err_q      <= '0;
      color_q    <= e_color;
    end else if (do_step) begin
      maj_pos_q <= maj_next;
      active_q  <= (maj_next != maj_stop_q);
      if (take_minor) begin
        min_pos_q <= down_q ? (min_pos_q - COORD_BITS'(1)) : (min_pos_q + COORD_BITS'(1));
        err_q     <= err_sum - $signed({2'b00, maj_span_q, 1'b0});
      end else begin
        err_q <= err_sum;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (do_step) begin
      px_q    <= px;
      py_q    <= py;
      pcol_q  <= color_q;
      onscr_q <= onscr;
      last_q  <= (maj_next == maj_stop_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign on_screen_o   = onscr_q;
  assign last_pixel_o  = last_q;

endmodule
